@@ rtl/oversample_average_ema_filter_unit_defines.svh @@
// Assertion macros for the oversampling average and EMA filter unit.
// Included by the RTL files that carry concurrent checks; needs no other file.
`ifndef OVERSAMPLE_AVERAGE_EMA_FILTER_UNIT_DEFINES_SVH
`define OVERSAMPLE_AVERAGE_EMA_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define OAEF_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("oaef check failed");

`define OAEF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("oaef check failed");

`else

`define OAEF_ASSERT_ALWAYS(label, clk, rst_n, expr)

`define OAEF_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/oaef_pkg.sv @@
// Types and constants of the oversampling average and EMA filter unit.
// Depends on nothing; used by the top level and the port declarations.
package oaef_pkg;

    localparam int DATA_W  = 16;
    localparam int ALPHA_W = 16;
    localparam int EMA_W   = 24;
    localparam int NUM_CH  = 2;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;

    typedef struct packed {
        logic                     sensor_sel;
        logic signed [DATA_W-1:0] sample_value;
        logic                     sample_valid;
    } t_in_item;

    typedef struct packed {
        logic                     out_sensor;
        logic                     read_ok;
        logic signed [DATA_W-1:0] burst_average;
        logic signed [DATA_W-1:0] filtered_value;
    } t_out_item;

endpackage

@@ rtl/oversample_average_ema_filter_unit.sv @@
// Per-sensor burst averager with an exponential moving average filter.
// Depends on oaef_pkg and oversample_average_ema_filter_unit_defines.svh.
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_ready   | oaef_pkg::t_in_item
//   out     | output    | o_out_valid / i_out_ready | oaef_pkg::t_out_item
//   cfg     | input     | i_cfg_valid / o_cfg_ready | ema_alpha, 16 bits
//
// A sample that does not end a burst is summed in the idle state. The last sample of a burst
// that updates a seeded filter steps through PREP, DIV, SIGN, LOAD, MUL and UPD: a restoring
// divider that yields one quotient bit per cycle (SUM_W steps) and a bit-serial multiply over
// the 16 bits of alpha. Seeding skips MUL and UPD; with no valid sample it goes to DONE.
// Reset is synchronous and clears the per-sensor state; a configuration write waits for idle.
// A stalled output holds its transaction in the output register; the unit takes new input
// until the next burst result needs that register.

`include "oversample_average_ema_filter_unit_defines.svh"

module oversample_average_ema_filter_unit #(
    parameter int SAMPLES_PER_BURST = 32,
    parameter int NUM_SENSORS       = 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  oaef_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output oaef_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [oaef_pkg::ALPHA_W-1:0]         i_cfg_data
);

    localparam int CNT_W  = $clog2(SAMPLES_PER_BURST + 1);
    localparam int IDX_W  = (SAMPLES_PER_BURST > 1) ? $clog2(SAMPLES_PER_BURST) : 1;
    localparam int SUM_W  = oaef_pkg::DATA_W + $clog2(SAMPLES_PER_BURST);
    localparam int STEP_W = $clog2(SUM_W);
    localparam int EMA_W  = oaef_pkg::EMA_W;
    localparam int DIFF_W = EMA_W + 1;
    localparam int DATA_W = oaef_pkg::DATA_W;
    localparam int NUM_CH = oaef_pkg::NUM_CH;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SAMPLES_PER_BURST - 1);
    localparam logic [4:0]       NUM_SENS  = 5'(NUM_SENSORS);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_PREP = 8'b0000_0010,
        ST_DIV  = 8'b0000_0100,
        ST_SIGN = 8'b0000_1000,
        ST_LOAD = 8'b0001_0000,
        ST_MUL  = 8'b0010_0000,
        ST_UPD  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } t_state;

    t_state                        r_state;
    logic [oaef_pkg::ALPHA_W-1:0]  r_alpha;
    logic                          r_out_valid;
    oaef_pkg::t_out_item           r_out;

    logic signed [SUM_W-1:0]       r_sum    [NUM_CH];
    logic [CNT_W-1:0]              r_vcnt   [NUM_CH];
    logic [IDX_W-1:0]              r_sidx   [NUM_CH];
    logic signed [EMA_W-1:0]       r_ema    [NUM_CH];
    logic                          r_seeded [NUM_CH];

    logic                          r_ch;
    logic                          r_ok;
    logic                          r_neg;
    logic [SUM_W-1:0]              r_dq;
    logic [CNT_W-1:0]              r_cnt;
    logic [CNT_W-1:0]              r_rem;
    logic [STEP_W-1:0]             r_step;
    logic signed [DATA_W-1:0]      r_avg;
    logic signed [DIFF_W-1:0]      r_diff;
    logic signed [DIFF_W-1:0]      r_acc;
    logic [oaef_pkg::ALPHA_W-1:0]  r_alpha_sh;

    logic                          w_ch;
    logic                          w_ch_ok;
    logic                          w_last;
    logic                          w_emit;
    logic signed [SUM_W-1:0]       n_sum;
    logic [CNT_W-1:0]              n_cnt;
    logic [CNT_W:0]                w_rem_sh;
    logic                          w_qbit;
    logic [CNT_W-1:0]              n_rem;
    logic signed [DATA_W-1:0]      n_avg;
    logic signed [EMA_W-1:0]       w_x;
    logic signed [DIFF_W-1:0]      n_diff;
    logic signed [DIFF_W:0]        w_add;
    logic signed [DIFF_W-1:0]      n_acc;
    logic signed [EMA_W-1:0]       n_ema;

    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        w_ch     = i_in_data.sensor_sel;
        w_ch_ok  = (5'(w_ch) < NUM_SENS);
        w_last   = (r_sidx[w_ch] == LAST_IDX);
        w_emit   = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
        n_sum    = r_sum[w_ch] + (i_in_data.sample_valid ?
                   SUM_W'(i_in_data.sample_value) : SUM_W'(0));
        n_cnt    = r_vcnt[w_ch] + CNT_W'(i_in_data.sample_valid);

        w_rem_sh = {r_rem, r_dq[SUM_W-1]};
        w_qbit   = (w_rem_sh >= {1'b0, r_cnt});
        n_rem    = w_qbit ? CNT_W'(w_rem_sh - {1'b0, r_cnt}) : w_rem_sh[CNT_W-1:0];

        n_avg    = r_neg ? -$signed(r_dq[DATA_W-1:0]) : $signed(r_dq[DATA_W-1:0]);
        w_x      = {r_avg, 8'b0};
        n_diff   = DIFF_W'(w_x) - DIFF_W'(r_ema[r_ch]);

        w_add    = (DIFF_W + 1)'(r_acc) + (r_alpha_sh[0] ? (DIFF_W + 1)'(r_diff)
                                                        : (DIFF_W + 1)'(0));
        n_acc    = w_add[DIFF_W:1];
        n_ema    = r_ema[r_ch] + r_acc[EMA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_alpha     <= oaef_pkg::ALPHA_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_sum[i]    <= '0;
                r_vcnt[i]   <= '0;
                r_sidx[i]   <= '0;
                r_ema[i]    <= '0;
                r_seeded[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_alpha <= i_cfg_data;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid && o_in_ready && w_ch_ok) begin
                        if (w_last) begin
                            r_sum[w_ch]  <= '0;
                            r_vcnt[w_ch] <= '0;
                            r_sidx[w_ch] <= '0;
                            r_state      <= (n_cnt == '0) ? ST_DONE : ST_PREP;
                        end else begin
                            r_sum[w_ch]  <= n_sum;
                            r_vcnt[w_ch] <= n_cnt;
                            r_sidx[w_ch] <= r_sidx[w_ch] + IDX_W'(1);
                        end
                    end
                end
                ST_PREP: r_state <= ST_DIV;
                ST_DIV: begin
                    if (r_step == '0) begin
                        r_state <= ST_SIGN;
                    end
                end
                ST_SIGN: r_state <= ST_LOAD;
                ST_LOAD: begin
                    if (r_seeded[r_ch]) begin
                        r_state <= ST_MUL;
                    end else begin
                        r_ema[r_ch]    <= w_x;
                        r_seeded[r_ch] <= 1'b1;
                        r_state        <= ST_DONE;
                    end
                end
                ST_MUL: begin
                    if (r_step == '0) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_ema[r_ch] <= n_ema;
                    r_state     <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_emit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ch  <= w_ch;
                r_dq  <= n_sum;
                r_neg <= n_sum[SUM_W-1];
                r_cnt <= n_cnt;
                r_ok  <= (n_cnt != '0);
                r_avg <= '0;
            end
            ST_PREP: begin
                if (r_neg) begin
                    r_dq <= -r_dq;
                end
                r_rem  <= '0;
                r_step <= STEP_W'(SUM_W - 1);
            end
            ST_DIV: begin
                r_rem  <= n_rem;
                r_dq   <= {r_dq[SUM_W-2:0], w_qbit};
                r_step <= r_step - STEP_W'(1);
            end
            ST_SIGN: r_avg <= n_avg;
            ST_LOAD: begin
                r_diff     <= n_diff;
                r_acc      <= '0;
                r_alpha_sh <= r_alpha;
                r_step     <= STEP_W'(oaef_pkg::ALPHA_W - 1);
            end
            ST_MUL: begin
                r_acc      <= n_acc;
                r_alpha_sh <= r_alpha_sh >> 1;
                r_step     <= r_step - STEP_W'(1);
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out.out_sensor     <= r_ch;
                    r_out.read_ok        <= r_ok;
                    r_out.burst_average  <= r_avg;
                    r_out.filtered_value <= r_ema[r_ch][EMA_W-1:8];
                end
            end
            default: ;
        endcase
    end

    `OAEF_ASSERT_ALWAYS(a_sidx_range, i_clk, i_rst_n,
        (r_sidx[0] <= LAST_IDX) && (r_sidx[1] <= LAST_IDX))
    `OAEF_ASSERT_ALWAYS(a_vcnt_le_sidx, i_clk, i_rst_n,
        (r_vcnt[0] <= r_sidx[0]) && (r_vcnt[1] <= r_sidx[1]))
    `OAEF_ASSERT_IMPL(a_mul_seeded, i_clk, i_rst_n, r_state == ST_MUL, r_seeded[r_ch])
    `OAEF_ASSERT_IMPL(a_quot_range, i_clk, i_rst_n, r_state == ST_SIGN, r_dq <= SUM_W'(32768))
    `OAEF_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n,
        o_out_valid && !o_out_data.read_ok, o_out_data.burst_average == 16'sd0)

endmodule
